@@ sv/cfrc_pkg.sv @@
// Shared types, sizes and codes for the copy-on-write frame reference-count table.
package cfrc_pkg;

    // BUCKETS must be a power of two so that the bucket hash is a bit mask.
    localparam int BUCKETS    = 64;
    localparam int WAYS       = 4;
    localparam int TABLE_SIZE = BUCKETS * WAYS;
    localparam int TBL_AW     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FRAME_W    = 20;
    localparam int COUNT_W    = 16;
    localparam int LIVE_W     = 9;
    localparam int STATUS_W   = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic {
        CMD_ADD     = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_SATURATED = 2'd3
    } t_status;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [COUNT_W-1:0] count;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the new item and clear the scan flags
        logic issue;    // read the next way of the bucket
        logic execute;  // apply the update and present the result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_issue;  // the way being read is the last of the bucket
    } t_dp_sts;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_LAST = 4'b0100,
        S_EXEC = 4'b1000
    } t_state;

endpackage

@@ sv/cfrc_ctrl.sv @@
// Controller state machine that sequences the bucket scan and the update.
module cfrc_ctrl
    import cfrc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                // The read data of the last way is compared in this cycle.
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ sv/cfrc_datapath.sv @@
// Datapath: entry memory, valid bits, way scan, update logic and result registers.
module cfrc_datapath
    import cfrc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic                i_item_cmd,
    input  logic [FRAME_W-1:0]  i_item_frame,
    output t_dp_sts             o_sts,
    output logic                o_result_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_others_remain,
    output logic [LIVE_W-1:0]   o_entries_in_use
);

    t_entry              r_mem [TABLE_SIZE];
    t_entry              r_rd_data;
    logic [TABLE_SIZE-1:0] r_valid;
    logic [LIVE_W-1:0]   r_live;

    logic                r_cmd;
    logic [FRAME_W-1:0]  r_frame;
    logic [TBL_AW-1:0]   r_base;
    logic [WAY_W-1:0]    r_way;
    logic                r_cmp_vld;
    logic [TBL_AW-1:0]   r_cmp_idx;

    logic                r_hit;
    logic [TBL_AW-1:0]   r_hit_idx;
    logic [COUNT_W-1:0]  r_hit_cnt;
    logic                r_free;
    logic [TBL_AW-1:0]   r_free_idx;

    logic                r_out_vld;
    t_status             r_status;
    logic                r_others;

    logic [TBL_AW-1:0]   rd_idx;
    logic                cmp_used;
    logic                cmp_match;

    t_status             n_status;
    logic                n_others;
    logic [LIVE_W-1:0]   n_live;
    logic                wr_en;
    logic [TBL_AW-1:0]   wr_idx;
    t_entry              wr_data;
    logic                set_valid;
    logic                clr_valid;

    assign rd_idx          = r_base + TBL_AW'(r_way);
    assign o_sts.last_issue = (r_way == WAY_W'(WAYS - 1));

    assign cmp_used  = r_valid[r_cmp_idx];
    assign cmp_match = cmp_used && (r_rd_data.frame == r_frame);

    // Outcome of the command, from the flags gathered during the scan.
    always_comb begin
        n_status  = ST_OK;
        n_others  = 1'b0;
        n_live    = r_live;
        wr_en     = 1'b0;
        wr_idx    = r_hit_idx;
        wr_data   = '{frame: r_frame, count: r_hit_cnt};
        set_valid = 1'b0;
        clr_valid = 1'b0;
        if (r_cmd == CMD_ADD) begin
            if (r_hit) begin
                if (r_hit_cnt == COUNT_MAX) begin
                    n_status = ST_SATURATED;
                end else begin
                    wr_en         = 1'b1;
                    wr_data.count = r_hit_cnt + COUNT_W'(1);
                end
            end else if (r_free) begin
                wr_en         = 1'b1;
                wr_idx        = r_free_idx;
                wr_data.count = COUNT_W'(1);
                set_valid     = 1'b1;
                n_live        = r_live + LIVE_W'(1);
            end else begin
                n_status = ST_FULL;
            end
        end else begin
            if (!r_hit) begin
                n_status = ST_NOT_FOUND;
            end else if (r_hit_cnt == COUNT_W'(1)) begin
                // Last sharer gone: free the entry, the caller keeps the frame.
                clr_valid = 1'b1;
                n_live    = r_live - LIVE_W'(1);
            end else begin
                wr_en         = 1'b1;
                wr_data.count = r_hit_cnt - COUNT_W'(1);
                n_others      = 1'b1;
            end
        end
    end

    // Entry memory: one read port for the scan, one write port for the update.
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[rd_idx];
        end
        if (i_cmd.execute && wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_item_cmd;
            r_frame <= i_item_frame;
            r_base  <= TBL_AW'((i_item_frame % FRAME_W'(BUCKETS)) * WAYS);
        end
        if (i_cmd.issue) begin
            r_cmp_idx <= rd_idx;
        end
        if (r_cmp_vld) begin
            if (cmp_match && !r_hit) begin
                r_hit_idx <= r_cmp_idx;
                r_hit_cnt <= r_rd_data.count;
            end
            if (!cmp_used && !r_free) begin
                r_free_idx <= r_cmp_idx;
            end
        end
        if (i_cmd.execute) begin
            r_status <= n_status;
            r_others <= n_others;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_live    <= '0;
            r_way     <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.issue;
            r_out_vld <= i_cmd.execute;
            if (i_cmd.load) begin
                r_way  <= '0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else begin
                if (i_cmd.issue) begin
                    r_way <= r_way + WAY_W'(1);
                end
                if (r_cmp_vld && cmp_match) begin
                    r_hit <= 1'b1;
                end
                if (r_cmp_vld && !cmp_used) begin
                    r_free <= 1'b1;
                end
            end
            if (i_cmd.execute) begin
                r_live <= n_live;
                if (set_valid) begin
                    r_valid[wr_idx] <= 1'b1;
                end
                if (clr_valid) begin
                    r_valid[r_hit_idx] <= 1'b0;
                end
            end
        end
    end

    assign o_result_valid   = r_out_vld;
    assign o_status         = r_status;
    assign o_others_remain  = r_others;
    assign o_entries_in_use = r_live;

endmodule

@@ sv/cow_frame_refcount_table.sv @@
// Top level of the copy-on-write frame reference-count table.
//
//   Channel   Ports                                          Handshake
//   item in   i_cmd, i_frame_number                          start && !busy
//   result    o_status, o_others_remain, o_entries_in_use    o_result_valid, one cycle
//
// The result strobe of an item rises after acceptance, once the bucket scan is
// done: one registered memory read per way of the bucket, the compare of the
// last way and then the update. busy is high from the first read through the
// update cycle, and a new item may be started in the cycle the strobe shows, so
// the table takes no new item until the last one is through.
// Reset clears the valid bits and the live count at once; no clearing pass.
// The receiver cannot stall; each result is shown for exactly one cycle.
module cow_frame_refcount_table
    import cfrc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cmd,
    input  logic [FRAME_W-1:0]  i_frame_number,
    output logic                o_result_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_others_remain,
    output logic [LIVE_W-1:0]   o_entries_in_use
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    ctrl_busy;

    cfrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (ctrl_busy),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    cfrc_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_item_cmd       (i_cmd),
        .i_item_frame     (i_frame_number),
        .o_sts            (dp_sts),
        .o_result_valid   (o_result_valid),
        .o_status         (o_status),
        .o_others_remain  (o_others_remain),
        .o_entries_in_use (o_entries_in_use)
    );

    assign busy = ctrl_busy;

endmodule
